// ===== rtl/core/page_buffer_pool_manager_defines.svh =====
// Assertion macros for the page buffer pool manager.
// Used by the top level; no dependencies.
`ifndef PAGE_BUFFER_POOL_MANAGER_DEFINES_SVH
`define PAGE_BUFFER_POOL_MANAGER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define PBPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbpm check failed");

// Assert that a condition implies a consequence in the next cycle.
`define PBPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbpm check failed");

`endif

// ===== rtl/core/pbpm_pkg.sv =====
// Shared types and constants of the page buffer pool manager.
// No dependencies.
`timescale 1ns / 1ps
package pbpm_pkg;
  localparam int FRAMES_DEF = 16;
  localparam int FILE_W = 10;
  localparam int PAGE_W = 24;
  localparam int PIN_W = 16;
  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  typedef enum logic [2:0] {
    OP_GET = 3'd0, OP_ALLOC = 3'd1, OP_DIRTY = 3'd2, OP_UNPIN = 3'd3,
    OP_FLUSH = 3'd4, OP_FORCE = 3'd5, OP_CLEAR = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOBUF = 3'd1, ST_INBUF = 3'd2, ST_NOTINBUF = 3'd3,
    ST_UNPINNED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_SWEEP, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [3:0]        frame_index;
    logic              read_needed;
    logic              writeback_valid;
    logic [FILE_W-1:0] writeback_file;
    logic [PAGE_W-1:0] writeback_page;
    logic              last;
  } result_t;
endpackage

// ===== rtl/core/pbpm_frame_mem.sv =====
// Frame table memory: file, page, pin count, dirty and valid per frame.
// Depends on pbpm_pkg. One write port, one registered read port.
`timescale 1ns / 1ps
module pbpm_frame_mem #(
  parameter int FRAMES = pbpm_pkg::FRAMES_DEF,
  parameter int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [AW-1:0]             rd_addr,
  output logic [pbpm_pkg::FILE_W-1:0] rd_file,
  output logic [pbpm_pkg::PAGE_W-1:0] rd_page,
  output logic [pbpm_pkg::PIN_W-1:0]  rd_pin,
  output logic                      rd_dirty,
  output logic                      rd_valid,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [pbpm_pkg::FILE_W-1:0] wr_file,
  input  logic [pbpm_pkg::PAGE_W-1:0] wr_page,
  input  logic [pbpm_pkg::PIN_W-1:0]  wr_pin,
  input  logic                      wr_dirty,
  input  logic                      wr_valid
);
  localparam int DW = pbpm_pkg::FILE_W + pbpm_pkg::PAGE_W;
  localparam int SW = pbpm_pkg::PIN_W + 2;
  logic [DW-1:0] mem_id [FRAMES];
  logic [SW-1:0] mem_st [FRAMES];
  logic [FRAMES-1:0] vld;
  logic [DW-1:0] id_q;
  logic [SW-1:0] st_q;
  logic          vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr] <= {wr_file, wr_page};
      mem_st[wr_addr] <= {wr_pin, wr_dirty, wr_valid};
    end
    id_q <= mem_id[rd_addr];
    st_q <= mem_st[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      vld_q <= vld[rd_addr];
    end
  end

  assign {rd_file, rd_page} = id_q;
  assign rd_pin   = vld_q ? st_q[SW-1:2] : '0;
  assign rd_dirty = vld_q & st_q[1];
  assign rd_valid = vld_q & st_q[0];
endmodule

// ===== rtl/core/page_buffer_pool_manager.sv =====
// Page buffer pool manager: frame table with lookup, pin and writeback.
// Depends on pbpm_pkg, pbpm_frame_mem and the defines header.
//
// Usage: one operation beat enters on s_axis (tdata = operation, file_id,
// page_number). Each operation yields one or more result beats on m_axis;
// the final one has tlast set. Flush and clear give one beat for each dirty
// frame of the file before the final beat.
// Table walk: the frame table sits in a memory with a registered read, and
// every operation walks it one frame per cycle, unless a flush or clear
// holds the walk. After the walk, the table update is applied and the final
// beat is loaded into the output register. A flush or clear writeback beat
// that meets a full output register holds the walk until it drains, then
// re-reads the frame.
// A new operation is taken only once the previous one has delivered its
// final beat.
// Reset clears all valid marks at once (per-frame valid flops), so frames
// read as empty, unpinned and clean; no clearing pass is needed.
// When the receiver stalls, the result beat holds in the output register until
// it is taken; a flush or clear walk pauses there only on a dirty frame.
`timescale 1ns / 1ps
`include "page_buffer_pool_manager_defines.svh"
module page_buffer_pool_manager #(
  parameter int FRAMES = pbpm_pkg::FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // operation[2:0], file_id[12:3], page_number[36:13]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status[2:0], frame_index[6:3], read_needed[7],
                                     // writeback_valid[8], writeback_file[18:9],
                                     // writeback_page[42:19]
  output logic        m_axis_tlast
);
  localparam int AW = $clog2(FRAMES + 1);
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [AW-1:0] LASTF = AW'(FRAMES - 1);
  localparam int FW = pbpm_pkg::FILE_W;
  localparam int PW = pbpm_pkg::PAGE_W;
  localparam int NW = pbpm_pkg::PIN_W;

  pbpm_pkg::state_t state, state_next;
  logic [2:0]  op;
  logic [FW-1:0] fid;
  logic [PW-1:0] pg;
  logic [AW-1:0] ra, ra_next;
  logic          rv;          // read data belongs to frame ra_q
  logic [AW-1:0] ra_q;
  logic          hit_f, free_f;
  logic [AW-1:0] hit_i, free_i;
  logic [NW-1:0] hit_pin;
  logic          hit_dirty;

  logic [FW-1:0] m_file;
  logic [PW-1:0] m_page;
  logic [NW-1:0] m_pin;
  logic          m_dirty, m_valid;
  logic          we;
  logic [AW-1:0] wa;
  logic [FW-1:0] wf;
  logic [PW-1:0] wp;
  logic [NW-1:0] wn;
  logic          wd, wv;

  pbpm_pkg::result_t res, obuf;
  logic ovalid;
  logic emit;

  pbpm_frame_mem #(.FRAMES(FRAMES), .AW(IW)) u_mem (
    .clk, .rst, .rd_addr(ra[IW-1:0]), .rd_file(m_file), .rd_page(m_page),
    .rd_pin(m_pin), .rd_dirty(m_dirty), .rd_valid(m_valid), .wr_en(we),
    .wr_addr(wa[IW-1:0]), .wr_file(wf), .wr_page(wp), .wr_pin(wn), .wr_dirty(wd),
    .wr_valid(wv)
  );

  logic out_free;
  assign out_free = !ovalid || m_axis_tready;
  assign s_axis_tready = (state == pbpm_pkg::S_IDLE);

  logic mmatch;
  assign mmatch = rv && m_valid && m_file == fid && m_page == pg;
  logic fmatch;
  assign fmatch = rv && m_valid && m_file == fid;

  // hold the sweep on a dirty frame while the output register is full
  logic sweep_hold;
  assign sweep_hold = (state == pbpm_pkg::S_SWEEP) && fmatch && m_dirty && !out_free;
  logic issue;
  assign issue = (state == pbpm_pkg::S_SCAN || state == pbpm_pkg::S_SWEEP) &&
                 ra != AW'(FRAMES) && !sweep_hold;

  always_comb begin
    state_next = state;
    ra_next = ra;
    we = 1'b0; wa = ra_q; wf = m_file; wp = m_page; wn = m_pin; wd = m_dirty; wv = m_valid;
    res = '0;
    res.last = 1'b1;
    emit = 1'b0;
    unique case (state)
      pbpm_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          ra_next = '0;
          if (s_axis_tdata[2:0] == pbpm_pkg::OP_FLUSH ||
              s_axis_tdata[2:0] == pbpm_pkg::OP_CLEAR)
            state_next = pbpm_pkg::S_SWEEP;
          else
            state_next = pbpm_pkg::S_SCAN;
        end
      end
      pbpm_pkg::S_SCAN: begin
        if (ra != AW'(FRAMES)) ra_next = ra + 1'b1;
        if (rv && ra_q == LASTF) state_next = pbpm_pkg::S_ACT;
      end
      pbpm_pkg::S_ACT: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = pbpm_pkg::S_OUT;
          unique case (op)
            pbpm_pkg::OP_GET, pbpm_pkg::OP_ALLOC: begin
              if (hit_f) begin
                res.frame_index = 4'(hit_i);
                if (op == pbpm_pkg::OP_ALLOC) res.status = pbpm_pkg::ST_INBUF;
                else if (hit_pin != pbpm_pkg::PIN_MAX) begin
                  we = 1'b1; wa = hit_i; wf = fid; wp = pg;
                  wn = hit_pin + 1'b1; wd = hit_dirty; wv = 1'b1;
                end
              end else if (!free_f) begin
                res.status = pbpm_pkg::ST_NOBUF;
              end else begin
                we = 1'b1; wa = free_i; wf = fid; wp = pg; wn = NW'(1); wd = 1'b0; wv = 1'b1;
                res.frame_index = 4'(free_i);
                res.read_needed = (op == pbpm_pkg::OP_GET);
              end
            end
            pbpm_pkg::OP_DIRTY, pbpm_pkg::OP_UNPIN: begin
              if (!hit_f) res.status = pbpm_pkg::ST_NOTINBUF;
              else begin
                res.frame_index = 4'(hit_i);
                if (hit_pin == '0) res.status = pbpm_pkg::ST_UNPINNED;
                else begin
                  we = 1'b1; wa = hit_i; wf = fid; wp = pg; wv = 1'b1;
                  if (op == pbpm_pkg::OP_DIRTY) begin
                    wn = hit_pin; wd = 1'b1;
                  end else begin
                    wn = hit_pin - 1'b1;
                    wd = hit_dirty && (hit_pin != NW'(1));
                    if (hit_dirty && hit_pin == NW'(1)) begin
                      res.writeback_valid = 1'b1;
                      res.writeback_file = fid;
                      res.writeback_page = pg;
                    end
                  end
                end
              end
            end
            pbpm_pkg::OP_FORCE: begin
              if (hit_f) begin
                res.frame_index = 4'(hit_i);
                if (hit_dirty) begin
                  we = 1'b1; wa = hit_i; wf = fid; wp = pg; wn = hit_pin; wd = 1'b0;
                  wv = 1'b1;
                  res.writeback_valid = 1'b1;
                  res.writeback_file = fid;
                  res.writeback_page = pg;
                end
              end
            end
            default: ;
          endcase
        end
      end
      pbpm_pkg::S_SWEEP: begin
        // rv with a matching dirty frame stalls until the writeback beat fits
        if (sweep_hold) begin
          ra_next = ra_q;
        end else begin
          if (ra != AW'(FRAMES)) ra_next = ra + 1'b1;
          if (fmatch) begin
            we = 1'b1;
            wd = 1'b0;
            if (op == pbpm_pkg::OP_CLEAR) begin
              wn = '0; wv = 1'b0;
            end
            if (m_dirty) begin
              emit = 1'b1;
              res.last = 1'b0;
              res.frame_index = 4'(ra_q);
              res.writeback_valid = 1'b1;
              res.writeback_file = fid;
              res.writeback_page = m_page;
            end
          end
          if (rv && ra_q == LASTF) state_next = pbpm_pkg::S_ACT;
        end
      end
      pbpm_pkg::S_OUT: begin
        if (out_free) state_next = pbpm_pkg::S_IDLE;
      end
      default: state_next = pbpm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbpm_pkg::S_IDLE;
      ra <= '0;
      rv <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ra <= ra_next;
      rv <= issue;
      if (emit) ovalid <= 1'b1;
      else if (m_axis_tready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pbpm_pkg::S_IDLE) begin
      op <= s_axis_tdata[2:0];
      fid <= s_axis_tdata[12:3];
      pg <= s_axis_tdata[36:13];
      hit_f <= 1'b0;
      free_f <= 1'b0;
    end
    ra_q <= ra;
    if (state == pbpm_pkg::S_SCAN && rv) begin
      if (mmatch && !hit_f) begin
        hit_f <= 1'b1; hit_i <= ra_q; hit_pin <= m_pin; hit_dirty <= m_dirty;
      end
      if (m_pin == '0 && !free_f) begin
        free_f <= 1'b1; free_i <= ra_q;
      end
    end
    if (emit) obuf <= res;
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tlast = obuf.last;
  assign m_axis_tdata = {5'd0, obuf.writeback_page, obuf.writeback_file,
                         obuf.writeback_valid, obuf.read_needed, obuf.frame_index,
                         obuf.status};

  `PBPM_ASSERT_IMP(a_busy_no_accept, state != pbpm_pkg::S_IDLE, !s_axis_tready)
  `PBPM_ASSERT_IMP(a_emit_room, emit, !ovalid || m_axis_tready)
  `PBPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PBPM_ASSERT_IMP(a_idle_drained, state == pbpm_pkg::S_IDLE && s_axis_tvalid,
                   !emit)
endmodule

// ===== dv/pbpm_checker.sv =====
// Checker for the page buffer pool manager: predicts result beats from accepted operations.
// Depends on pbpm_pkg; watches both stream channels and reports a failure count.
`timescale 1ns / 1ps
module pbpm_checker
  import pbpm_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          failures,
  output int          outstanding,
  output int          beats_seen,
  output int          writebacks_seen
);
  logic              fr_valid [FRAMES];
  logic [FILE_W-1:0] fr_file  [FRAMES];
  logic [PAGE_W-1:0] fr_page  [FRAMES];
  logic [PIN_W-1:0]  fr_pins  [FRAMES];
  logic              fr_dirty [FRAMES];

  result_t due_beats[$];

  function automatic result_t mk(status_t st, int fr, logic rd, logic wbv,
                                 logic [FILE_W-1:0] wbf, logic [PAGE_W-1:0] wbp,
                                 logic lst);
    result_t r;
    r.status          = st;
    r.frame_index     = (fr < 0) ? 4'd0 : fr[3:0];
    r.read_needed     = rd;
    r.writeback_valid = wbv;
    r.writeback_file  = wbv ? wbf : '0;
    r.writeback_page  = wbv ? wbp : '0;
    r.last            = lst;
    return r;
  endfunction

  task automatic predict_operation(op_t op, logic [FILE_W-1:0] f, logic [PAGE_W-1:0] p);
    int hit;
    int fr;
    hit = -1;
    fr = -1;
    for (int i = FRAMES - 1; i >= 0; i--)
      if (fr_valid[i] && fr_file[i] == f && fr_page[i] == p) hit = i;
    case (op)
      OP_GET, OP_ALLOC: begin
        if (hit >= 0) begin
          if (op == OP_ALLOC) begin
            due_beats.push_back(mk(ST_INBUF, hit, 0, 0, 0, 0, 1));
          end else begin
            if (fr_pins[hit] != PIN_MAX) fr_pins[hit]++;
            due_beats.push_back(mk(ST_OK, hit, 0, 0, 0, 0, 1));
          end
        end else begin
          for (int i = FRAMES - 1; i >= 0; i--)
            if (fr_pins[i] == '0) fr = i;
          if (fr < 0) begin
            due_beats.push_back(mk(ST_NOBUF, -1, 0, 0, 0, 0, 1));
          end else begin
            fr_valid[fr] = 1'b1;
            fr_file[fr]  = f;
            fr_page[fr]  = p;
            fr_pins[fr]  = 1;
            fr_dirty[fr] = 1'b0;
            due_beats.push_back(mk(ST_OK, fr, op == OP_GET, 0, 0, 0, 1));
          end
        end
      end
      OP_DIRTY, OP_UNPIN: begin
        if (hit < 0) begin
          due_beats.push_back(mk(ST_NOTINBUF, -1, 0, 0, 0, 0, 1));
        end else if (fr_pins[hit] == '0) begin
          due_beats.push_back(mk(ST_UNPINNED, hit, 0, 0, 0, 0, 1));
        end else if (op == OP_DIRTY) begin
          fr_dirty[hit] = 1'b1;
          due_beats.push_back(mk(ST_OK, hit, 0, 0, 0, 0, 1));
        end else begin
          fr_pins[hit]--;
          if (fr_pins[hit] == '0 && fr_dirty[hit]) begin
            fr_dirty[hit] = 1'b0;
            due_beats.push_back(mk(ST_OK, hit, 0, 1, f, p, 1));
          end else begin
            due_beats.push_back(mk(ST_OK, hit, 0, 0, 0, 0, 1));
          end
        end
      end
      OP_FLUSH, OP_CLEAR: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (fr_valid[i] && fr_file[i] == f) begin
            if (fr_dirty[i]) begin
              fr_dirty[i] = 1'b0;
              due_beats.push_back(mk(ST_OK, i, 0, 1, f, fr_page[i], 0));
            end
            if (op == OP_CLEAR) begin
              fr_valid[i] = 1'b0;
              fr_pins[i]  = '0;
            end
          end
        end
        due_beats.push_back(mk(ST_OK, -1, 0, 0, 0, 0, 1));
      end
      OP_FORCE: begin
        if (hit >= 0 && fr_dirty[hit]) begin
          fr_dirty[hit] = 1'b0;
          due_beats.push_back(mk(ST_OK, hit, 0, 1, f, p, 1));
        end else begin
          due_beats.push_back(mk(ST_OK, hit, 0, 0, 0, 0, 1));
        end
      end
      default: due_beats.push_back(mk(ST_OK, -1, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic compare_beat();
    result_t want;
    result_t got;
    got.status          = m_axis_tdata[2:0];
    got.frame_index     = m_axis_tdata[6:3];
    got.read_needed     = m_axis_tdata[7];
    got.writeback_valid = m_axis_tdata[8];
    got.writeback_file  = m_axis_tdata[18:9];
    got.writeback_page  = m_axis_tdata[42:19];
    got.last            = m_axis_tlast;
    beats_seen++;
    if (m_axis_tdata[8]) writebacks_seen++;
    if (due_beats.size() == 0) begin
      $error("result beat with nothing expected: tdata %h tlast %b", m_axis_tdata,
             m_axis_tlast);
      failures++;
      return;
    end
    want = due_beats.pop_front();
    if (got.status != want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      failures++;
    end
    if (got.frame_index != want.frame_index) begin
      $error("frame_index: expected %0d, actual %0d", want.frame_index, got.frame_index);
      failures++;
    end
    if (got.read_needed != want.read_needed) begin
      $error("read_needed: expected %0d, actual %0d", want.read_needed, got.read_needed);
      failures++;
    end
    if (got.writeback_valid != want.writeback_valid) begin
      $error("writeback_valid: expected %0d, actual %0d", want.writeback_valid,
             got.writeback_valid);
      failures++;
    end
    if (got.writeback_file != want.writeback_file) begin
      $error("writeback_file: expected %0d, actual %0d", want.writeback_file,
             got.writeback_file);
      failures++;
    end
    if (got.writeback_page != want.writeback_page) begin
      $error("writeback_page: expected %h, actual %h", want.writeback_page,
             got.writeback_page);
      failures++;
    end
    if (got.last != want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      failures++;
    end
  endtask

  initial begin
    failures = 0;
    outstanding = 0;
    beats_seen = 0;
    writebacks_seen = 0;
    for (int i = 0; i < FRAMES; i++) begin
      fr_valid[i] = 1'b0;
      fr_file[i]  = '0;
      fr_page[i]  = '0;
      fr_pins[i]  = '0;
      fr_dirty[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) compare_beat();
      if (s_axis_tvalid && s_axis_tready)
        predict_operation(op_t'(s_axis_tdata[2:0]), s_axis_tdata[12:3], s_axis_tdata[36:13]);
      outstanding = due_beats.size();
    end
  end
endmodule

// ===== dv/tb_page_buffer_pool_manager.sv =====
// Testbench top for the page buffer pool manager: clock, reset, operation stimulus, verdict.
// Depends on pbpm_pkg, pbpm_checker and the page_buffer_pool_manager RTL.
`timescale 1ns / 1ps
module tb_page_buffer_pool_manager;
  import pbpm_pkg::*;

  localparam int STALL_LIMIT = 6000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  int failures;
  int outstanding;
  int beats_seen;
  int writebacks_seen;
  int ops_sent;
  int idle_cycles;
  bit calm;

  logic [FILE_W-1:0] file_pool [4];
  logic [PAGE_W-1:0] page_pool [12];

  page_buffer_pool_manager u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  pbpm_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .failures(failures), .outstanding(outstanding),
    .beats_seen(beats_seen), .writebacks_seen(writebacks_seen)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // hold the operation beat until taken
  task automatic send_op(op_t op, logic [FILE_W-1:0] f, logic [PAGE_W-1:0] p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, p, f, op};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    ops_sent++;
  endtask

  task automatic random_op();
    int pick;
    op_t op;
    logic [FILE_W-1:0] f;
    logic [PAGE_W-1:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = OP_GET;
    else if (pick < 34) op = OP_ALLOC;
    else if (pick < 50) op = OP_DIRTY;
    else if (pick < 76) op = OP_UNPIN;
    else if (pick < 84) op = OP_FLUSH;
    else if (pick < 92) op = OP_FORCE;
    else if (pick < 97) op = OP_CLEAR;
    else op = OP_NONE;
    if ($urandom_range(0, 9) == 0) begin
      f = FILE_W'($urandom);
      p = PAGE_W'($urandom);
    end else begin
      f = file_pool[$urandom_range(0, 3)];
      p = page_pool[$urandom_range(0, 11)];
    end
    send_op(op, f, p);
  endtask

  // receiver: stall a random number of cycles ahead of each beat
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge clk);
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    ops_sent = 0;
    idle_cycles = 0;
    calm = 1'b0;
    file_pool[0] = '0;
    file_pool[1] = '1;
    file_pool[2] = FILE_W'($urandom);
    file_pool[3] = FILE_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 12; i++) page_pool[i] = PAGE_W'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_op(OP_GET, 10'd0, 24'd0);
    send_op(OP_GET, 10'd0, 24'd0);
    send_op(OP_ALLOC, 10'd0, 24'd0);
    send_op(OP_ALLOC, 10'h3FF, 24'hFFFFFF);
    send_op(OP_DIRTY, 10'h3FF, 24'hFFFFFF);
    send_op(OP_UNPIN, 10'h3FF, 24'hFFFFFF);
    send_op(OP_UNPIN, 10'h3FF, 24'hFFFFFF);
    send_op(OP_DIRTY, 10'h3FF, 24'hFFFFFF);
    send_op(OP_DIRTY, 10'd5, 24'd5);
    send_op(OP_UNPIN, 10'd5, 24'd5);
    send_op(OP_DIRTY, 10'd0, 24'd0);
    send_op(OP_FORCE, 10'd0, 24'd0);
    send_op(OP_FORCE, 10'd0, 24'd0);
    send_op(OP_FORCE, 10'd5, 24'd5);
    send_op(OP_DIRTY, 10'd0, 24'd0);
    send_op(OP_FLUSH, 10'd0, 24'd0);
    send_op(OP_DIRTY, 10'd0, 24'd0);
    send_op(OP_CLEAR, 10'd0, 24'd0);
    send_op(OP_NONE, 10'h2AA, 24'h555555);
    // fill every frame, then miss with no frame free
    for (int i = 0; i < 16; i++) begin
      send_op(OP_ALLOC, 10'd2, PAGE_W'(100 + i));
      if (i % 3 == 0) send_op(OP_DIRTY, 10'd2, PAGE_W'(100 + i));
    end
    send_op(OP_GET, 10'd2, 24'd999);
    send_op(OP_CLEAR, 10'd2, 24'd0);

    for (int n = 0; n < 427; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      random_op();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d operations, %0d result beats, %0d of them writebacks",
             ops_sent, beats_seen, writebacks_seen);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
